[hdl/bbq_pkg.sv]
// ----------------------------------------------------------------------------
// Bounding box quantizer package
// Shared constants and the per-axis control bundle for the quantizer.
// ----------------------------------------------------------------------------
package bbq_pkg;

    // Width and reset value of the bit depth register.
    localparam int DEPTH_W = 5;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;

    // Number of coordinate axes handled in parallel.
    localparam int NUM_AXES = 3;

    // Step strobes that the sequencer sends to every axis datapath.
    typedef struct packed {
        logic load;     // capture the coordinate of an accepted quantize transaction
        logic prep;     // form the axis range and the offset from the low bound
        logic shift;    // form the step and the magnitude of the offset
        logic iter;     // one restoring remainder step
        logic fix;      // turn the magnitude remainder into a floor remainder
        logic adj;      // form the correction that is added to the coordinate
    } t_axis_ctl;

endpackage

[hdl/bounding_box_coordinate_quantizer.sv]
// ----------------------------------------------------------------------------
// Bounding box coordinate quantizer
// Gathers per-axis bounds of 3-D vertices and snaps vertices to a grid.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid / o_in_ready) carries one vertex per
// transaction together with a mode bit. A gather transaction (mode 0) widens
// the per-axis bounds, or restarts them when i_first is set, in the cycle it
// is accepted; it produces no output transaction and the block is ready again
// on the next cycle. A quantize transaction (mode 1) produces exactly one
// output transaction (o_out_valid / i_out_ready) holding the three snapped
// coordinates and a zero-step flag.
// A quantize transaction passes through the prepare, shift, remainder, fix,
// adjust and done states; the remainder state runs the bit-serial restoring
// remainder unit, one step per dividend bit, and the three axes run in
// parallel. Only one vertex is in flight, so a new quantize transaction is
// accepted only after the sequencer has returned to idle.
// The result sits in an output register, so a new vertex can be accepted
// while the previous result waits. If the receiver stalls and a second result
// is finished, the block holds it internally and accepts nothing more.
// Reset clears the bounds to zero, sets bit_depth to 8 and empties the output.
// i_cfg_we writes bit_depth at once; write it only while the block is idle.
// ----------------------------------------------------------------------------
module bounding_box_coordinate_quantizer #(
    parameter int COORD_WIDTH   = 32,
    parameter int MAX_BIT_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bbq_pkg::DEPTH_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic                               i_first,
    input  logic signed [COORD_WIDTH-1:0]      i_x_in,
    input  logic signed [COORD_WIDTH-1:0]      i_y_in,
    input  logic signed [COORD_WIDTH-1:0]      i_z_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [COORD_WIDTH-1:0]      o_x_out,
    output logic signed [COORD_WIDTH-1:0]      o_y_out,
    output logic signed [COORD_WIDTH-1:0]      o_z_out,
    output logic                               o_zero_step
);

    localparam int W     = COORD_WIDTH;
    localparam int CNT_W = $clog2(W + 2);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_FIX   = 7'b0010000,
        S_ADJ   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [CNT_W-1:0]             r_cnt;
    logic [CNT_W-1:0]             n_cnt;
    logic [bbq_pkg::DEPTH_W-1:0]  r_bit_depth;
    logic                         r_out_valid;
    logic signed [W-1:0]          r_x_out;
    logic signed [W-1:0]          r_y_out;
    logic signed [W-1:0]          r_z_out;
    logic                         r_zero_step;

    logic                         w_in_accept;
    logic                         w_gather;
    logic                         w_out_free;
    logic                         w_load_out;
    logic [bbq_pkg::DEPTH_W-1:0]  w_depth;
    bbq_pkg::t_axis_ctl           w_ctl;

    logic signed [W-1:0] w_coord  [bbq_pkg::NUM_AXES];
    logic signed [W-1:0] w_low    [bbq_pkg::NUM_AXES];
    logic signed [W-1:0] w_high   [bbq_pkg::NUM_AXES];
    logic signed [W-1:0] w_result [bbq_pkg::NUM_AXES];
    logic [bbq_pkg::NUM_AXES-1:0] w_zero;

    assign w_coord[0] = i_x_in;
    assign w_coord[1] = i_y_in;
    assign w_coord[2] = i_z_in;

    // The block takes a new vertex only when no quantize is in flight.
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_gather    = w_in_accept && !i_mode;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load_out  = (r_state == S_DONE) && w_out_free;

    // A bit depth of zero acts as one; values above the maximum are clipped.
    always_comb begin
        if (r_bit_depth == '0) begin
            w_depth = bbq_pkg::DEPTH_W'(1);
        end else if (r_bit_depth > bbq_pkg::DEPTH_W'(MAX_BIT_DEPTH)) begin
            w_depth = bbq_pkg::DEPTH_W'(MAX_BIT_DEPTH);
        end else begin
            w_depth = r_bit_depth;
        end
    end

    // Strobes for the axis datapaths follow directly from the state; load comes from an accepted quantize.
    always_comb begin
        w_ctl.load  = w_in_accept && i_mode;
        w_ctl.prep  = (r_state == S_PREP);
        w_ctl.shift = (r_state == S_SHIFT);
        w_ctl.iter  = (r_state == S_DIV);
        w_ctl.fix   = (r_state == S_FIX);
        w_ctl.adj   = (r_state == S_ADJ);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept && i_mode) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                // One remainder step per dividend bit, COORD_WIDTH + 1 in all.
                if (r_cnt == CNT_W'(W)) begin
                    n_state = S_FIX;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIX: begin
                n_state = S_ADJ;
            end
            S_ADJ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_bit_depth <= bbq_pkg::DEPTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_bit_depth <= i_cfg_data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_x_out     <= w_result[0];
            r_y_out     <= w_result[1];
            r_z_out     <= w_result[2];
            r_zero_step <= |w_zero;
        end
    end

    for (genvar g = 0; g < bbq_pkg::NUM_AXES; g++) begin : g_axis
        bbq_bounds #(
            .COORD_WIDTH (W)
        ) u_bounds (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_gather(w_gather),
            .i_first (i_first),
            .i_coord (w_coord[g]),
            .o_low   (w_low[g]),
            .o_high  (w_high[g])
        );

        bbq_axis #(
            .COORD_WIDTH (W)
        ) u_axis (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_depth (w_depth),
            .i_coord (w_coord[g]),
            .i_low   (w_low[g]),
            .i_high  (w_high[g]),
            .o_result(w_result[g]),
            .o_zero  (w_zero[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_x_out     = r_x_out;
    assign o_y_out     = r_y_out;
    assign o_z_out     = r_z_out;
    assign o_zero_step = r_zero_step;

    // A quantize transaction always starts the sequencer.
    a_quant_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode) |=> (r_state == S_PREP))
        else $error("quantize transaction did not start the sequencer");

    // A gather transaction leaves the block ready for the next vertex.
    a_gather_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_mode) |=> o_in_ready)
        else $error("gather transaction left the block busy");

    // The remainder counter never passes the last dividend bit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_W'(W)))
        else $error("remainder counter overran");

    // A finished result is presented on the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (o_out_valid && o_in_ready))
        else $error("finished result was not presented");

endmodule

[hdl/bbq_bounds.sv]
// ----------------------------------------------------------------------------
// Bounding box quantizer bounds register
// Holds the low and high bound of one axis and widens them on gather.
// ----------------------------------------------------------------------------
module bbq_bounds #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_gather,
    input  logic                          i_first,
    input  logic signed [COORD_WIDTH-1:0] i_coord,
    output logic signed [COORD_WIDTH-1:0] o_low,
    output logic signed [COORD_WIDTH-1:0] o_high
);

    logic signed [COORD_WIDTH-1:0] r_low;
    logic signed [COORD_WIDTH-1:0] r_high;
    logic signed [COORD_WIDTH-1:0] n_low;
    logic signed [COORD_WIDTH-1:0] n_high;

    // A first vertex restarts the box; otherwise the box only grows.
    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        if (i_gather) begin
            if (i_first) begin
                n_low  = i_coord;
                n_high = i_coord;
            end else begin
                if (i_coord > r_high) begin
                    n_high = i_coord;
                end
                if (i_coord < r_low) begin
                    n_low = i_coord;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    assign o_low  = r_low;
    assign o_high = r_high;

endmodule

[hdl/bbq_axis.sv]
// ----------------------------------------------------------------------------
// Bounding box quantizer axis datapath
// Snaps one coordinate to its axis grid with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module bbq_axis #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  bbq_pkg::t_axis_ctl              i_ctl,
    input  logic [bbq_pkg::DEPTH_W-1:0]     i_depth,
    input  logic signed [COORD_WIDTH-1:0]   i_coord,
    input  logic signed [COORD_WIDTH-1:0]   i_low,
    input  logic signed [COORD_WIDTH-1:0]   i_high,
    output logic signed [COORD_WIDTH-1:0]   o_result,
    output logic                            o_zero
);

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] r_c;
    logic [W-1:0]        r_range;
    logic signed [W:0]   r_d;
    logic [W-1:0]        r_step;
    logic                r_neg;
    logic [W:0]          r_mag;
    logic [W-1:0]        r_rem;
    logic                r_zero;
    logic signed [W:0]   r_delta;

    logic [W:0]          w_diff;
    logic [W:0]          w_d;
    logic [W:0]          w_trial;
    logic [W:0]          w_sub;
    logic                w_ge;
    logic                w_up;
    logic signed [W+1:0] w_sum;

    always_comb begin
        w_diff  = {i_high[W-1], i_high} - {i_low[W-1], i_low};
        w_d     = {r_c[W-1], r_c} - {i_low[W-1], i_low};
        // The dividend magnitude enters the partial remainder one bit a cycle.
        w_trial = {r_rem, r_mag[W]};
        w_ge    = w_trial >= {1'b0, r_step};
        w_sub   = w_trial - {1'b0, r_step};
        // Round up when twice the remainder exceeds the step.
        w_up    = {r_rem, 1'b0} > {1'b0, r_step};
        w_sum   = {r_c[W-1], r_c[W-1], r_c} + {r_delta[W], r_delta};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_c <= i_coord;
        end
        if (i_ctl.prep) begin
            r_range <= w_diff[W] ? '0 : w_diff[W-1:0];
            r_d     <= $signed(w_d);
        end
        if (i_ctl.shift) begin
            r_step <= r_range >> i_depth;
            r_neg  <= r_d[W];
            r_mag  <= r_d[W] ? $unsigned(-r_d) : $unsigned(r_d);
            r_rem  <= '0;
        end
        if (i_ctl.iter) begin
            r_rem <= w_ge ? w_sub[W-1:0] : w_trial[W-1:0];
            r_mag <= {r_mag[W-1:0], 1'b0};
        end
        if (i_ctl.fix) begin
            // A negative offset with a nonzero remainder wraps to the floor remainder.
            if (r_neg && (r_rem != '0)) begin
                r_rem <= r_step - r_rem;
            end
            r_zero <= (r_step == '0);
        end
        if (i_ctl.adj) begin
            r_delta <= w_up ? ($signed({1'b0, r_step}) - $signed({1'b0, r_rem}))
                            : (-$signed({1'b0, r_rem}));
        end
    end

    // A zero step passes the coordinate through; otherwise saturate the snapped value to the coordinate range.
    always_comb begin
        if (r_zero) begin
            o_result = r_c;
        end else if ((w_sum[W+1:W-1] == '0) || (w_sum[W+1:W-1] == '1)) begin
            o_result = w_sum[W-1:0];
        end else if (w_sum[W+1]) begin
            o_result = {1'b1, {(W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(W-1){1'b1}}};
        end
    end

    assign o_zero = r_zero;

endmodule
